### sv/hduart_pkg.sv
// Shared types and constants for the half-duplex 8N1 UART.
// No dependencies; used by hduart_core and half_duplex_uart_8n1_unit.
`default_nettype none

package hduart_pkg;

  localparam int unsigned TICK_COUNTER_BITS = 16;
  localparam int unsigned FRAME_BITS        = 10;

  localparam logic [15:0] BIT_PERIOD_RESET = 16'd104;
  localparam logic [3:0]  RX_SAMPLES       = 4'd10;
  localparam logic [3:0]  TX_BITS_AFTER_START = 4'd9;

  // one timebase tick as it enters the core
  typedef struct packed {
    logic       rx_line;
    logic       send_request;
    logic [7:0] send_byte;
    logic       take_received;
  } tick_t;

  // status word produced for every tick
  typedef struct packed {
    logic       tx_line;
    logic       send_accepted;
    logic       sending;
    logic       receiving;
    logic       received_ready;
    logic [7:0] received_byte;
  } status_t;

endpackage

`default_nettype wire

### sv/hduart_core.sv
// Frame state and per-tick update logic of the half-duplex 8N1 UART.
// Depends on hduart_pkg for the tick and status word types.
`default_nettype none

module hduart_core #(
  parameter int unsigned TickBits = hduart_pkg::TICK_COUNTER_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire hduart_pkg::tick_t   tick_i,
  input  wire logic [15:0]         bit_period_i,
  output hduart_pkg::status_t      status_o
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2
  } mode_e;

  localparam int unsigned FB = hduart_pkg::FRAME_BITS;

  mode_e             mode_q, mode_d;
  logic [TickBits-1:0] cnt_q, cnt_d;
  logic [3:0]        bits_q, bits_d;
  logic [FB-1:0]     shift_q, shift_d;
  logic              line_q, line_d;
  logic [7:0]        held_byte_q, held_byte_d;
  logic              held_valid_q, held_valid_d;
  logic              prev_rx_q, prev_rx_d;
  logic              accepted;

  logic [TickBits-1:0] period_raw, half_raw, period, half;

  // register truncated/extended to the counter width; zero acts as one
  assign period_raw = TickBits'(bit_period_i);
  assign half_raw   = period_raw >> 1;
  assign period     = (period_raw == '0) ? TickBits'(1) : period_raw;
  assign half       = (half_raw == '0) ? TickBits'(1) : half_raw;

  always_comb begin
    mode_d       = mode_q;
    cnt_d        = cnt_q;
    bits_d       = bits_q;
    shift_d      = shift_q;
    line_d       = line_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    accepted     = 1'b0;

    // take clears first, so a frame ending this tick sets the flag again
    if (tick_i.take_received) begin
      held_valid_d = 1'b0;
    end

    case (mode_q)
      MODE_RX: begin
        if (cnt_q <= TickBits'(1)) begin
          shift_d = {tick_i.rx_line, shift_q[FB-1:1]};
          bits_d  = bits_q - 4'd1;
          cnt_d   = period;
          if (bits_d == 4'd0) begin
            mode_d = MODE_IDLE;
            if (shift_d[FB-1] && !shift_d[0]) begin
              held_byte_d  = shift_d[8:1];
              held_valid_d = 1'b1;
            end
          end
        end else begin
          cnt_d = cnt_q - TickBits'(1);
        end
      end
      MODE_TX: begin
        if (cnt_q <= TickBits'(1)) begin
          if (bits_q == 4'd0) begin
            mode_d = MODE_IDLE;
            line_d = 1'b1;
            cnt_d  = '0;
          end else begin
            line_d  = shift_q[0];
            shift_d = {1'b0, shift_q[FB-1:1]};
            bits_d  = bits_q - 4'd1;
            cnt_d   = period;
          end
        end else begin
          cnt_d = cnt_q - TickBits'(1);
        end
      end
      default: begin
        // idle, and the unused code behaves the same
        mode_d = MODE_IDLE;
        if (prev_rx_q && !tick_i.rx_line) begin
          mode_d  = MODE_RX;
          cnt_d   = half;
          bits_d  = hduart_pkg::RX_SAMPLES;
          shift_d = '0;
        end else if (tick_i.send_request) begin
          mode_d   = MODE_TX;
          accepted = 1'b1;
          line_d   = 1'b0;
          shift_d  = {2'b01, tick_i.send_byte};
          bits_d   = hduart_pkg::TX_BITS_AFTER_START;
          cnt_d    = period;
        end
      end
    endcase

    prev_rx_d = tick_i.rx_line;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      cnt_q        <= '0;
      bits_q       <= '0;
      shift_q      <= '0;
      line_q       <= 1'b1;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      prev_rx_q    <= 1'b1;
    end else if (step_i) begin
      mode_q       <= mode_d;
      cnt_q        <= cnt_d;
      bits_q       <= bits_d;
      shift_q      <= shift_d;
      line_q       <= line_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      prev_rx_q    <= prev_rx_d;
    end
  end

  always_comb begin
    status_o.tx_line        = line_d;
    status_o.send_accepted  = accepted;
    status_o.sending        = (mode_d == MODE_TX);
    status_o.receiving      = (mode_d == MODE_RX);
    status_o.received_ready = held_valid_d;
    status_o.received_byte  = held_byte_d;
  end

  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= hduart_pkg::RX_SAMPLES)
    else $error("bit counter out of range");

  a_accept_starts_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && status_o.send_accepted |=> mode_q == MODE_TX && !line_q)
    else $error("accepted send did not start a frame");

  a_idle_line_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != MODE_TX |-> line_q)
    else $error("tx line low outside a transmit frame");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && status_o.send_accepted |-> !status_o.receiving)
    else $error("send accepted while receiving");

endmodule

`default_nettype wire

### sv/half_duplex_uart_8n1_unit.sv
// Half-duplex 8N1 UART: one timebase tick per input word, one status word out.
// The input channel feeds an input register, the core updates the frame state,
// and each status word lands in an output register before it leaves.
// Use: drive one tick word per timebase tick on the in_* channel (receive pin
// level, optional send request with byte, take of the held received byte).
// Every accepted tick yields exactly one status word on the out_* channel.
// An accepted tick goes from the input register through the combinational
// core update into the output register; its status word is presented on
// out_valid_o. Throughput: one tick per clock unless the output stalls.
// A stalled output (out_ready_i low) holds the status word; one more tick
// may wait in the input register, after which in_ready_o drops until the
// output is taken. bit_period is written on the cfg_* channel, always
// ready, and must only change while no tick is in flight.
// Reset: no words in flight, receiver and transmitter idle, core tx line at
// mark, no held byte, bit_period back to 104 (out_* data is not reset).
`default_nettype none

module half_duplex_uart_8n1_unit #(
  parameter int unsigned TickBits = hduart_pkg::TICK_COUNTER_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tick input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        rx_line_i,
  input  wire logic        send_request_i,
  input  wire logic [7:0]  send_byte_i,
  input  wire logic        take_received_i,
  // status output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             tx_line_o,
  output logic             send_accepted_o,
  output logic             sending_o,
  output logic             receiving_o,
  output logic             received_ready_o,
  output logic [7:0]       received_byte_o,
  // bit period register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  logic                in_valid_q, in_valid_d;
  hduart_pkg::tick_t   in_q;
  logic                out_valid_q, out_valid_d;
  hduart_pkg::status_t out_q, status;
  logic [15:0]         period_q;
  logic                out_free, step;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      period_q    <= hduart_pkg::BIT_PERIOD_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        period_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q.rx_line       <= rx_line_i;
      in_q.send_request  <= send_request_i;
      in_q.send_byte     <= send_byte_i;
      in_q.take_received <= take_received_i;
    end
    if (step) begin
      out_q <= status;
    end
  end

  hduart_core #(
    .TickBits(TickBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .tick_i      (in_q),
    .bit_period_i(period_q),
    .status_o    (status)
  );

  assign out_valid_o      = out_valid_q;
  assign tx_line_o        = out_q.tx_line;
  assign send_accepted_o  = out_q.send_accepted;
  assign sending_o        = out_q.sending;
  assign receiving_o      = out_q.receiving;
  assign received_ready_o = out_q.received_ready;
  assign received_byte_o  = out_q.received_byte;

endmodule

`default_nettype wire
